// File: rtl/core/lprd_pkg.sv
// Package for the length-prefixed request deframer: widths, codes, result
// and step records shared by the front, queue, back and top level.
// No dependencies.
package lprd_pkg;

  // Internal counter widths
  localparam int LENGTH_BITS    = 16;
  localparam int ARG_COUNT_BITS = 11;

  // Fixed field and register widths
  localparam int MAX_LEN_W = 16;
  localparam int MAX_ARG_W = 11;
  localparam int ARG_IDX_W = 10;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam int ARG_CAP   = 1024;
  localparam int CNT_MAX   = (1 << ARG_COUNT_BITS) - 1;
  localparam int ARG_LIM_I = (ARG_CAP < CNT_MAX) ? ARG_CAP : CNT_MAX;
  localparam logic [MAX_ARG_W-1:0] ARG_LIMIT = MAX_ARG_W'(ARG_LIM_I);
  localparam logic [31:0] LEN_MAX = 32'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [LENGTH_BITS-1:0] MIN_FIELD = LENGTH_BITS'(4);

  // Register indexes (byte address bit 2)
  localparam logic REG_MAX_MSG_LEN = 1'b0;
  localparam logic REG_MAX_ARGS    = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd1;
  localparam logic [2:0] ERR_TOO_SHORT = 3'd2;
  localparam logic [2:0] ERR_TOO_MANY  = 3'd3;
  localparam logic [2:0] ERR_FIELD_OVR = 3'd4;
  localparam logic [2:0] ERR_ARG_OVR   = 3'd5;
  localparam logic [2:0] ERR_TRAILING  = 3'd6;

  // Step queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           data_byte;
    logic [ARG_IDX_W-1:0] arg_index;
    logic                 arg_last;
    logic                 msg_end;
    logic [2:0]           error_code;
  } result_t;

  // Everything one input byte causes: one or two results
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } step_t;

  typedef struct packed {
    logic [MAX_LEN_W-1:0] max_message_length;
    logic [MAX_ARG_W-1:0] max_arguments;
  } cfg_t;

  function automatic result_t err_result(logic [2:0] code);
    result_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

endpackage

// File: rtl/core/lprd_if.sv
// Stream channel interfaces of the deframer: input byte channel and result
// channel, valid/ready handshake. Depends on lprd_pkg.
interface lprd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lprd_out_if;
  import lprd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [7:0]           data_byte;
  logic [ARG_IDX_W-1:0] arg_index;
  logic                 arg_last;
  logic                 msg_end;
  logic [2:0]           error_code;
  logic                 run_last;

  modport source (output valid, output kind, output data_byte, output arg_index,
                  output arg_last, output msg_end, output error_code,
                  output run_last, input ready);
  modport sink   (input valid, input kind, input data_byte, input arg_index,
                  input arg_last, input msg_end, input error_code,
                  input run_last, output ready);
endinterface

// File: rtl/core/lprd_front.sv
// Deframer front: accepts bytes, runs the framing state machine and pushes
// one step record per byte that causes results. Depends on lprd_pkg, lprd_if.
module lprd_front (
  input  logic               clk,
  input  logic               rst,
  lprd_in_if.sink            in_ch,
  input  lprd_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               push,
  output lprd_pkg::step_t    step
);
  import lprd_pkg::*;

  localparam logic [1:0] PH_OUTER   = 2'd0;
  localparam logic [1:0] PH_COUNT   = 2'd1;
  localparam logic [1:0] PH_ARGLEN  = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  logic [1:0]                phase, phase_next;
  logic [1:0]                fbc, fbc_next;
  logic [23:0]               shift, shift_next;
  logic [LENGTH_BITS-1:0]    mbl, mbl_next;
  logic [LENGTH_BITS-1:0]    abl, abl_next;
  logic [ARG_COUNT_BITS-1:0] args_left, args_left_next;
  logic [ARG_IDX_W-1:0]      cur_arg, cur_arg_next;
  logic                      halted, halted_next;

  logic                      accept;
  logic                      do_finish;
  logic [LENGTH_BITS-1:0]    mbl_dec;
  logic [LENGTH_BITS-1:0]    abl_dec;
  logic [ARG_COUNT_BITS-1:0] args_dec;
  logic [31:0]               v;
  logic [MAX_ARG_W-1:0]      cap;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign mbl_dec     = mbl - LENGTH_BITS'(1);
  assign abl_dec     = abl - LENGTH_BITS'(1);
  assign args_dec    = args_left - ARG_COUNT_BITS'(1);
  assign v           = {in_ch.rx_byte, shift};
  assign cap         = (cfg.max_arguments > ARG_LIMIT) ? ARG_LIMIT : cfg.max_arguments;

  always_comb begin
    phase_next     = phase;
    fbc_next       = fbc;
    shift_next     = shift;
    mbl_next       = mbl;
    abl_next       = abl;
    args_left_next = args_left;
    cur_arg_next   = cur_arg;
    halted_next    = halted;
    push           = 1'b0;
    step           = '0;
    do_finish      = 1'b0;

    if (accept && !halted) begin
      if (phase == PH_PAYLOAD) begin
        mbl_next            = mbl_dec;
        abl_next            = abl_dec;
        push                = 1'b1;
        step.r0.kind        = KIND_BYTE;
        step.r0.data_byte   = in_ch.rx_byte;
        step.r0.arg_index   = cur_arg;
        step.r0.arg_last    = (abl_dec == '0);
        do_finish           = (abl_dec == '0);
      end else begin
        if (phase != PH_OUTER) begin
          mbl_next = mbl_dec;
        end
        fbc_next = fbc + 2'd1;
        if (fbc != 2'd3) begin
          shift_next[{fbc, 3'b000} +: 8] = in_ch.rx_byte;
        end else begin
          case (phase)
            PH_OUTER: begin
              if (v > LEN_MAX || v > 32'(cfg.max_message_length)) begin
                push = 1'b1; step.r0 = err_result(ERR_TOO_LONG); halted_next = 1'b1;
              end else if (v < 32'd4) begin
                push = 1'b1; step.r0 = err_result(ERR_TOO_SHORT); halted_next = 1'b1;
              end else begin
                mbl_next   = v[LENGTH_BITS-1:0];
                phase_next = PH_COUNT;
              end
            end
            PH_COUNT: begin
              cur_arg_next = '0;
              if (v > 32'(cap)) begin
                push = 1'b1; step.r0 = err_result(ERR_TOO_MANY); halted_next = 1'b1;
              end else if (v == 32'd0) begin
                push = 1'b1;
                if (mbl_dec == '0) begin
                  step.r0.kind    = KIND_DONE;
                  step.r0.msg_end = 1'b1;
                  phase_next      = PH_OUTER;
                end else begin
                  step.r0 = err_result(ERR_TRAILING); halted_next = 1'b1;
                end
              end else begin
                args_left_next = v[ARG_COUNT_BITS-1:0];
                if (mbl_dec < MIN_FIELD) begin
                  push = 1'b1; step.r0 = err_result(ERR_FIELD_OVR); halted_next = 1'b1;
                end else begin
                  phase_next = PH_ARGLEN;
                end
              end
            end
            default: begin
              // argument length field
              if (v > 32'(mbl_dec)) begin
                push = 1'b1; step.r0 = err_result(ERR_ARG_OVR); halted_next = 1'b1;
              end else if (v == 32'd0) begin
                push              = 1'b1;
                step.r0.kind      = KIND_EMPTY;
                step.r0.arg_index = cur_arg;
                step.r0.arg_last  = 1'b1;
                do_finish         = 1'b1;
              end else begin
                abl_next   = v[LENGTH_BITS-1:0];
                phase_next = PH_PAYLOAD;
              end
            end
          endcase
        end
      end
    end

    // End of an argument: r0 is already used, any error goes to r1
    if (do_finish) begin
      args_left_next = args_dec;
      if (args_dec == '0) begin
        cur_arg_next = '0;
        if (mbl_next == '0) begin
          step.r0.msg_end = 1'b1;
          phase_next      = PH_OUTER;
        end else begin
          step.two = 1'b1; step.r1 = err_result(ERR_TRAILING); halted_next = 1'b1;
        end
      end else begin
        cur_arg_next = cur_arg + ARG_IDX_W'(1);
        if (mbl_next < MIN_FIELD) begin
          step.two = 1'b1; step.r1 = err_result(ERR_FIELD_OVR); halted_next = 1'b1;
        end else begin
          phase_next = PH_ARGLEN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OUTER;
      fbc       <= '0;
      mbl       <= '0;
      abl       <= '0;
      args_left <= '0;
      cur_arg   <= '0;
      halted    <= 1'b0;
    end else begin
      phase     <= phase_next;
      fbc       <= fbc_next;
      mbl       <= mbl_next;
      abl       <= abl_next;
      args_left <= args_left_next;
      cur_arg   <= cur_arg_next;
      halted    <= halted_next;
    end
  end

  // field accumulator: every byte lane is rewritten before it is used
  always_ff @(posedge clk) begin
    shift <= shift_next;
  end

endmodule

// File: rtl/core/lprd_queue.sv
// Step queue between deframer front and back: small FIFO of step records.
// Depends on lprd_pkg.
module lprd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lprd_pkg::step_t push_step,
  input  logic            pop,
  output logic            full,
  output logic            q_valid,
  output lprd_pkg::step_t head
);
  import lprd_pkg::*;

  step_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_step;
    end
  end

endmodule

// File: rtl/core/lprd_back.sv
// Deframer back: takes step records from the queue and delivers their one
// or two results on the output channel. Depends on lprd_pkg, lprd_if.
module lprd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  lprd_pkg::step_t head,
  output logic            pop,
  lprd_out_if.source      out_ch
);
  import lprd_pkg::*;

  step_t   cur;
  logic    cur_valid;
  logic    second;
  logic    fin;
  result_t sel;

  assign sel = second ? cur.r1 : cur.r0;
  assign fin = cur_valid && out_ch.ready && (second || !cur.two);
  assign pop = q_valid && (!cur_valid || fin);

  assign out_ch.valid      = cur_valid;
  assign out_ch.kind       = sel.kind;
  assign out_ch.data_byte  = sel.data_byte;
  assign out_ch.arg_index  = sel.arg_index;
  assign out_ch.arg_last   = sel.arg_last;
  assign out_ch.msg_end    = sel.msg_end;
  assign out_ch.error_code = sel.error_code;
  assign out_ch.run_last   = second || !cur.two;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      second    <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      second    <= 1'b0;
    end else if (fin) begin
      cur_valid <= 1'b0;
      second    <= 1'b0;
    end else if (cur_valid && out_ch.ready) begin
      second    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule

// File: rtl/core/length_prefixed_request_deframer_top.sv
// Length-prefixed request deframer, top level: APB registers, front, queue, back.
// A byte's results pass through the step queue and the back's output register.
// Throughput: one byte per cycle while the step queue has room; a byte causing two
//   results needs a second output transaction, absorbed by the 4-entry step queue.
// Reset: synchronous, active high; framing state, queue and output cleared,
//   max_message_length = 4096, max_arguments = 1024.
module length_prefixed_request_deframer_top (
  input  logic                         clk,
  input  logic                         rst,
  lprd_in_if.sink                      in_ch,
  lprd_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lprd_pkg::APB_AW-1:0]  paddr,
  input  logic [lprd_pkg::APB_DW-1:0]  pwdata,
  output logic [lprd_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import lprd_pkg::*;

  // Configuration registers
  logic [MAX_LEN_W-1:0] max_message_length;
  logic [MAX_ARG_W-1:0] max_arguments;
  logic                 reg_idx;
  logic                 wr_en;
  cfg_t                 cfg;

  // Front to queue, queue to back
  logic  push;
  step_t push_step;
  logic  q_full;
  logic  q_valid;
  step_t head;
  logic  pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];   // registers at byte 0 and 4
  assign wr_en   = psel && penable && pwrite;

  // Read back: each register zero-extended to the data bus
  assign prdata = (reg_idx == REG_MAX_ARGS) ? APB_DW'(max_arguments)
                                             : APB_DW'(max_message_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_length <= MAX_LEN_W'(4096);
      max_arguments      <= MAX_ARG_W'(1024);
    end else if (wr_en) begin
      if (reg_idx == REG_MAX_MSG_LEN) begin
        max_message_length <= pwdata[MAX_LEN_W-1:0];
      end else begin
        max_arguments <= pwdata[MAX_ARG_W-1:0];
      end
    end
  end

  assign cfg.max_message_length = max_message_length;
  assign cfg.max_arguments      = max_arguments;

  // Front: framing state machine, one byte per cycle while the queue has room
  lprd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .step   (push_step)
  );

  // Queue of step records; decouples input stalls from output stalls
  lprd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_step (push_step),
    .pop       (pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .head      (head)
  );

  // Back: registered output, unpacks two-result steps over two transactions
  lprd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// File: tb/sv/tb_length_prefixed_request_deframer_top.sv
`timescale 1ns / 100ps
// Testbench for length_prefixed_request_deframer_top: drives framed byte streams,
// predicts every deframed result and checks it. Depends on lprd_pkg, lprd_if.
module tb_length_prefixed_request_deframer_top;
  import lprd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 8;    // covers the back's output register and the step queue
  localparam int unsigned LONG_HOLD    = 400;  // receiver hold-off in the pressure test
  localparam int unsigned RANDOM_BYTES = 330;

  // Parser phases of the predictor
  typedef enum logic [1:0] {
    WAIT_LENGTH,
    WAIT_COUNT,
    WAIT_ARG_LEN,
    IN_PAYLOAD
  } parse_phase_t;

  // One expected result, with the end-of-run flag of its input byte
  typedef struct packed {
    result_t res;
    logic    run_last;
  } deframed_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  lprd_in_if  byte_in ();
  lprd_out_if result_out ();

  length_prefixed_request_deframer_top uut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (byte_in),
    .out_ch  (result_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Deframer predictor: its own copy of the registers and the parser state
  // ---------------------------------------------------------------------------
  logic [MAX_LEN_W-1:0]      limit_len;
  logic [MAX_ARG_W-1:0]      limit_args;

  parse_phase_t              phase;
  logic [1:0]                field_cnt;
  logic [31:0]               field_acc;
  logic [LENGTH_BITS-1:0]    msg_left;
  logic [ARG_COUNT_BITS-1:0] args_left;
  logic [ARG_IDX_W-1:0]      cur_arg;
  logic [LENGTH_BITS-1:0]    arg_left;
  logic                      halted;

  result_t   byte_results[$];     // results of the byte being predicted
  deframed_t pending_results[$];  // expected, not yet seen on the output

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned cycles;
  bit          no_idle;
  bit          hold_request;
  int unsigned ready_hold;
  logic [7:0]  frame_bytes[$];
  deframed_t   want;

  function automatic void reset_model();
    limit_len  = 16'd4096;
    limit_args = 11'd1024;
    phase      = WAIT_LENGTH;
    field_cnt  = '0;
    field_acc  = '0;
    msg_left   = '0;
    args_left  = '0;
    cur_arg    = '0;
    arg_left   = '0;
    halted     = 1'b0;
  endfunction

  function automatic result_t make_result(logic [1:0] kind, logic [7:0] data,
                                          logic [ARG_IDX_W-1:0] idx, logic last,
                                          logic done, logic [2:0] code);
    result_t r;
    r.kind       = kind;
    r.data_byte  = data;
    r.arg_index  = idx;
    r.arg_last   = last;
    r.msg_end    = done;
    r.error_code = code;
    return r;
  endfunction

  // Any framing error latches the parser until reset
  function automatic void flag_error(logic [2:0] code);
    byte_results = {byte_results, make_result(KIND_ERROR, '0, '0, 1'b0, 1'b0, code)};
    halted = 1'b1;
  endfunction

  // An argument has been fully delivered: next argument, message end, or error
  function automatic void close_argument();
    args_left = args_left - 1'b1;
    if (args_left == 0) begin
      cur_arg = '0;
      if (msg_left == 0) begin
        if (byte_results.size() > 0)
          byte_results[byte_results.size()-1].msg_end = 1'b1;
        phase = WAIT_LENGTH;
      end else begin
        flag_error(ERR_TRAILING);
      end
    end else begin
      cur_arg = cur_arg + 1'b1;
      if (msg_left < 4) flag_error(ERR_FIELD_OVR);
      else phase = WAIT_ARG_LEN;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    logic [31:0]          v;
    logic [MAX_ARG_W-1:0] cap;
    deframed_t            d;
    byte_results.delete();
    if (halted) return;
    if (phase == IN_PAYLOAD) begin
      msg_left = msg_left - 1'b1;
      arg_left = arg_left - 1'b1;
      byte_results = {byte_results, make_result(KIND_BYTE, b, cur_arg, arg_left == 0,
                                                1'b0, ERR_NONE)};
      if (arg_left == 0) close_argument();
    end else begin
      field_acc = field_acc | (32'(b) << (8 * field_cnt));
      if (phase != WAIT_LENGTH) msg_left = msg_left - 1'b1;
      field_cnt = field_cnt + 1'b1;
      if (field_cnt == 0) begin
        v         = field_acc;
        field_acc = '0;
        case (phase)
          WAIT_LENGTH: begin
            if (v > limit_len || v > LEN_MAX) flag_error(ERR_TOO_LONG);
            else if (v < 4) flag_error(ERR_TOO_SHORT);
            else begin
              msg_left = v[LENGTH_BITS-1:0];
              phase    = WAIT_COUNT;
            end
          end
          WAIT_COUNT: begin
            cap = (limit_args > ARG_LIMIT) ? ARG_LIMIT : limit_args;
            cur_arg = '0;
            if (v > cap) flag_error(ERR_TOO_MANY);
            else if (v == 0) begin
              if (msg_left == 0) begin
                byte_results = {byte_results, make_result(KIND_DONE, '0, '0, 1'b0, 1'b1,
                                                          ERR_NONE)};
                phase = WAIT_LENGTH;
              end else begin
                flag_error(ERR_TRAILING);
              end
            end else begin
              args_left = v[ARG_COUNT_BITS-1:0];
              if (msg_left < 4) flag_error(ERR_FIELD_OVR);
              else phase = WAIT_ARG_LEN;
            end
          end
          default: begin
            if (v > msg_left) flag_error(ERR_ARG_OVR);
            else if (v == 0) begin
              byte_results = {byte_results, make_result(KIND_EMPTY, '0, cur_arg, 1'b1, 1'b0,
                                                        ERR_NONE)};
              close_argument();
            end else begin
              arg_left = v[LENGTH_BITS-1:0];
              phase    = IN_PAYLOAD;
            end
          end
        endcase
      end
    end
    foreach (byte_results[i]) begin
      d.res      = byte_results[i];
      d.run_last = (i == byte_results.size() - 1);
      pending_results = {pending_results, d};
    end
  endfunction

  // Predict on every accepted input transaction
  always @(posedge clk) begin
    if (!rst && byte_in.valid && byte_in.ready) predict_byte(byte_in.rx_byte);
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted output transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d, error_code %0d", result_out.kind,
               result_out.error_code);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("kind",       want.res.kind,       result_out.kind);
        compare_field("data_byte",  want.res.data_byte,  result_out.data_byte);
        compare_field("arg_index",  want.res.arg_index,  result_out.arg_index);
        compare_field("arg_last",   want.res.arg_last,   result_out.arg_last);
        compare_field("msg_end",    want.res.msg_end,    result_out.msg_end);
        compare_field("error_code", want.res.error_code, result_out.error_code);
        compare_field("run_last",   want.run_last,       result_out.run_last);
      end
    end
  end

  // Idle lengths: mostly none, some short, a few long
  function automatic int unsigned gap_cycles();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request (counted here)
  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      ready_hold   = LONG_HOLD;
      result_out.ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold--;
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 99) < 20) ready_hold = gap_cycles();
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_length_prefixed_request_deframer_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One input transaction, after a random idle gap; valid stays high afterwards
  task automatic send_byte(input logic [7:0] value);
    int unsigned idle;
    idle = gap_cycles();
    if (idle > 0) begin
      byte_in.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    byte_in.valid   <= 1'b1;
    byte_in.rx_byte <= value;
    do @(posedge clk); while (!byte_in.ready);
    bytes_sent++;
  endtask

  task automatic transmit();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    frame_bytes.delete();
  endtask

  // 32-bit little-endian field
  function automatic void put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) frame_bytes = {frame_bytes, w[8*i +: 8]};
  endfunction

  // Well-formed message with the given argument lengths and random payload
  function automatic void frame_args(int unsigned lens[$]);
    int unsigned total;
    total = 4;
    foreach (lens[i]) total += 4 + lens[i];
    put_word(total);
    put_word(lens.size());
    foreach (lens[i]) begin
      put_word(lens[i]);
      repeat (lens[i]) frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
    end
  endfunction

  // Random message that fits the current limits
  task automatic send_random_message();
    int unsigned lens[$];
    int unsigned budget;
    int unsigned cap;
    int unsigned count;
    int unsigned len;
    int unsigned r;
    budget = limit_len - 4;
    cap    = (limit_args > ARG_LIMIT) ? ARG_LIMIT : limit_args;
    r      = $urandom_range(0, 99);
    count  = (r < 10) ? 0 : (r < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
    if (count > cap) count = cap;
    for (int i = 0; i < count && budget >= 4; i++) begin
      r   = $urandom_range(0, 99);
      len = (r < 15) ? 0 : (r < 88) ? $urandom_range(1, 8) : $urandom_range(9, 60);
      if (len > budget - 4) len = budget - 4;
      lens = {lens, len};
      budget -= 4 + len;
    end
    frame_args(lens);
    transmit();
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic drain();
    byte_in.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup then access; strobes drop in a cycle of their own
  task automatic write_register(input logic reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_MAX_MSG_LEN) limit_len = value[MAX_LEN_W-1:0];
    else limit_args = value[MAX_ARG_W-1:0];
    @(posedge clk);
  endtask

  task automatic reconfigure(input int unsigned max_len, input int unsigned max_args);
    drain();
    write_register(REG_MAX_MSG_LEN, max_len);
    write_register(REG_MAX_ARGS, max_args);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero-argument message (done marker) and a lone empty argument
  task automatic test_empty_messages();
    put_word(4);
    put_word(0);
    frame_args('{0});
    transmit();
  endtask

  // Payload byte extremes and an empty argument between two full ones
  task automatic test_payload_extremes();
    put_word(20);
    put_word(3);
    put_word(2);
    frame_bytes = {frame_bytes, 8'h00};
    frame_bytes = {frame_bytes, 8'hFF};
    put_word(0);
    put_word(2);
    frame_bytes = {frame_bytes, 8'h55};
    frame_bytes = {frame_bytes, 8'hAA};
    transmit();
  endtask

  // Register extremes, messages exactly at the limits, argument limit above range
  task automatic test_register_extremes();
    reconfigure(4, 0);
    put_word(4);
    put_word(0);
    transmit();
    reconfigure(40, 3);
    frame_args('{8, 8, 8});
    transmit();
    reconfigure(65535, 2047);
    frame_args('{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1});
    transmit();
  endtask

  // Long receiver hold-off while the sender keeps offering at full rate
  task automatic test_backpressure();
    reconfigure(4096, 1024);
    hold_request = 1'b1;
    no_idle      = 1'b1;
    repeat (6) send_random_message();
    no_idle = 1'b0;
    drain();
  endtask

  // Stretch with no idling on either side
  task automatic test_full_rate();
    no_idle = 1'b1;
    repeat (3) send_random_message();
    no_idle = 1'b0;
    drain();
  endtask

  // Well-formed random traffic under changing limits
  task automatic test_random_traffic();
    int unsigned target;
    int unsigned cfg_mark;
    target   = bytes_sent + RANDOM_BYTES;
    cfg_mark = bytes_sent;
    while (bytes_sent < target) begin
      if (bytes_sent - cfg_mark > 220) begin
        reconfigure(($urandom_range(0, 1) == 0) ? $urandom_range(12, 300)
                                                : $urandom_range(300, 65535),
                    ($urandom_range(0, 99) < 15) ? $urandom_range(0, 3)
                                                 : $urandom_range(4, 2047));
        cfg_mark = bytes_sent;
      end
      send_random_message();
    end
    drain();
  endtask

  // One framing error (it latches until reset), then noise that must be dropped
  task automatic test_framing_error();
    int unsigned pick;
    int unsigned len_cap;
    int unsigned arg_cap;
    logic [31:0] len_field;
    pick    = $urandom_range(0, 8);
    len_cap = 4096;
    arg_cap = 1024;
    if (pick == 0) len_cap = $urandom_range(4, 5000);
    if (pick == 1) len_cap = 65535;
    if (pick == 3) arg_cap = $urandom_range(0, 10);
    reconfigure(len_cap, arg_cap);
    case (pick)
      0: put_word(len_cap + $urandom_range(1, 5000));  // over the register limit
      1: begin                                         // over what the length counter holds
        len_field = $urandom | 32'h0001_0000;
        put_word(len_field);
      end
      2: put_word($urandom_range(0, 3));               // under 4
      3: begin                                         // too many arguments
        put_word(8);
        put_word(arg_cap + $urandom_range(1, 500));
      end
      4: begin                                         // no arguments but bytes left
        put_word($urandom_range(5, 64));
        put_word(0);
      end
      5: begin                                         // no room for the first length field
        put_word($urandom_range(5, 7));
        put_word($urandom_range(1, 9));
      end
      6: begin                                         // no room for the next length field
        put_word(11);
        put_word(2);
        put_word(1);
        frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
      end
      7: begin                                         // argument overruns the message
        put_word(12);
        put_word(1);
        put_word($urandom_range(5, 100));
      end
      default: begin                                   // trailing bytes after the last argument
        put_word(13);
        put_word(1);
        put_word(2);
        frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
        frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
      end
    endcase
    repeat (16) frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
    transmit();
  endtask

  initial begin
    rst              = 1'b1;
    byte_in.valid    = 1'b0;
    byte_in.rx_byte  = '0;
    result_out.ready = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    mismatches       = 0;
    bytes_sent       = 0;
    cycles           = 0;
    no_idle          = 1'b0;
    hold_request     = 1'b0;
    ready_hold       = 0;
    reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_messages();
    test_payload_extremes();
    test_register_extremes();
    test_backpressure();
    test_full_rate();
    test_random_traffic();
    test_framing_error();
    drain();

    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_length_prefixed_request_deframer_top: clean");
    else
      $display("tb_length_prefixed_request_deframer_top: errors");
    $finish;
  end

endmodule
